@@ rtl/rma_pkg.sv @@
`default_nettype none

package rma_pkg;

	localparam int WINDOW_LEN = 16;

	localparam int SAMPLE_W = 16;
	localparam int LIMIT_W  = 20;
	localparam int AVG_W    = 24;
	localparam int FRAC_W   = 8;

	localparam int PTR_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
	localparam int CNT_W = $clog2(WINDOW_LEN + 1);
	localparam int SUM_W = SAMPLE_W + $clog2(WINDOW_LEN);
	localparam int CMP_W = SUM_W + LIMIT_W;

	// dividend is |sum| << FRAC_W, one quotient bit per divide step
	localparam int DVD_W    = SUM_W + FRAC_W;
	localparam int STEP_W   = $clog2(DVD_W + 1);

	localparam logic [AVG_W-1:0] AVG_EMPTY = {1'b0, {(AVG_W-1){1'b1}}};

	localparam logic ACT_ADD   = 1'b0;
	localparam logic ACT_CLEAR = 1'b1;

endpackage

`default_nettype wire

@@ rtl/ring_moving_average_top.sv @@
`default_nettype none

// moving average over a ring of the last rma_pkg::WINDOW_LEN signed samples
//
// input channel: in_valid / in_stall with action and sample. action clear
// drops the pointer, fill count, full flag and running sum; action add writes
// the sample into the ring and updates the sum.
// output channel: out_valid / out_stall with one result item per input item:
// mean in Q.8 (truncated toward zero, maximum value when empty), empty flag,
// fill count, full flag and ready flag (full, or sum above ready_limit).
// ready_limit is written through cfg_wr_en / cfg_wr_data; the user must
// write it only while idle, as the block does not enforce this.
// one item at a time: in_stall is high from acceptance until the result is
// loaded into the output register. an add reads the ring at acceptance, does
// the read-modify-write in ST_READ, sets up the divide in ST_PREP, runs DVD_W
// (28) divide steps in ST_DIVIDE and loads the result in ST_DONE. a clear
// skips ST_READ and the divide. the restoring divider, one quotient bit
// per cycle, sets the rate. a result waiting under out_stall does not block
// the next item, but the following result waits until the output is taken.
// reset (arst_n low) clears the control state and ready_limit; ring contents
// are not cleared and never used before being written.

module ring_moving_average_top (
	input  wire logic                        clk,
	input  wire logic                        arst_n,

	input  wire logic                        cfg_wr_en,
	input  wire logic [rma_pkg::LIMIT_W-1:0] cfg_wr_data,

	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic                        action,
	input  wire logic [rma_pkg::SAMPLE_W-1:0] sample,

	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [rma_pkg::AVG_W-1:0]        average_q8,
	output logic                             empty_res,
	output logic [rma_pkg::CNT_W-1:0]        sample_count,
	output logic                             window_full,
	output logic                             ready_res
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_PREP,
		ST_DIVIDE,
		ST_DONE
	} state_t;

	state_t state_q;

	logic [rma_pkg::SAMPLE_W-1:0] ring_mem [rma_pkg::WINDOW_LEN];
	logic [rma_pkg::SAMPLE_W-1:0] rd_data_q;
	logic [rma_pkg::SAMPLE_W-1:0] sample_q;

	logic [rma_pkg::PTR_W-1:0]   wp_q;
	logic [rma_pkg::CNT_W-1:0]   count_q;
	logic                        full_q;
	logic signed [rma_pkg::SUM_W-1:0] sum_q;
	logic signed [rma_pkg::LIMIT_W-1:0] limit_q;

	logic [rma_pkg::DVD_W-1:0]   quo_q;
	logic [rma_pkg::CNT_W-1:0]   rem_q;
	logic [rma_pkg::STEP_W-1:0]  step_q;
	logic                        neg_q;

	logic in_take;
	logic out_free;
	logic mem_wr_en;

	logic signed [rma_pkg::SUM_W-1:0] sum_add;
	logic signed [rma_pkg::SUM_W-1:0] sum_next;
	logic [rma_pkg::SUM_W-1:0]        sum_mag;
	logic [rma_pkg::CNT_W:0]          trial;
	logic                             trial_ge;
	logic [rma_pkg::DVD_W-1:0]        quo_signed;
	logic signed [rma_pkg::CMP_W-1:0] sum_cmp;
	logic signed [rma_pkg::CMP_W-1:0] limit_cmp;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_take   = in_valid && !in_stall;
	assign out_free  = !out_valid || !out_stall;
	assign mem_wr_en = (state_q == ST_READ);

	always_comb begin
		sum_add = sum_q + {{(rma_pkg::SUM_W-rma_pkg::SAMPLE_W){sample_q[rma_pkg::SAMPLE_W-1]}},
			sample_q};
		if (full_q) begin
			sum_next = sum_add - {{(rma_pkg::SUM_W-rma_pkg::SAMPLE_W){rd_data_q[rma_pkg::SAMPLE_W-1]}},
				rd_data_q};
		end else begin
			sum_next = sum_add;
		end
	end

	assign sum_mag = sum_q[rma_pkg::SUM_W-1] ? (~sum_q + 1'b1) : sum_q;

	assign trial    = {rem_q, quo_q[rma_pkg::DVD_W-1]};
	assign trial_ge = (trial >= {1'b0, count_q});

	assign quo_signed = neg_q ? (~quo_q + 1'b1) : quo_q;

	assign sum_cmp   = {{(rma_pkg::CMP_W-rma_pkg::SUM_W){sum_q[rma_pkg::SUM_W-1]}}, sum_q};
	assign limit_cmp = {{(rma_pkg::CMP_W-rma_pkg::LIMIT_W){limit_q[rma_pkg::LIMIT_W-1]}}, limit_q};

	// ring: read at acceptance; an add writes back the next cycle, same entry
	always_ff @(posedge clk) begin
		if (in_take) begin
			rd_data_q <= ring_mem[wp_q];
		end
		if (mem_wr_en) begin
			ring_mem[wp_q] <= sample_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= '0;
		end else if (cfg_wr_en) begin
			limit_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			wp_q      <= '0;
			count_q   <= '0;
			full_q    <= 1'b0;
			sum_q     <= '0;
			step_q    <= '0;
			out_valid <= 1'b0;
		end else begin
			// a new result loaded in ST_DONE replaces the one taken this cycle
			if (out_valid && !out_stall && (state_q != ST_DONE)) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						sample_q <= sample;
						if (action == rma_pkg::ACT_CLEAR) begin
							wp_q    <= '0;
							count_q <= '0;
							full_q  <= 1'b0;
							sum_q   <= '0;
							state_q <= ST_PREP;
						end else begin
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					sum_q <= sum_next;
					if (wp_q == rma_pkg::PTR_W'(rma_pkg::WINDOW_LEN - 1)) begin
						wp_q <= '0;
					end else begin
						wp_q <= wp_q + 1'b1;
					end
					if (count_q < rma_pkg::CNT_W'(rma_pkg::WINDOW_LEN)) begin
						count_q <= count_q + 1'b1;
						if (count_q == rma_pkg::CNT_W'(rma_pkg::WINDOW_LEN - 1)) begin
							full_q <= 1'b1;
						end
					end
					state_q <= ST_PREP;
				end
				ST_PREP: begin
					quo_q  <= {sum_mag, {rma_pkg::FRAC_W{1'b0}}};
					rem_q  <= '0;
					neg_q  <= sum_q[rma_pkg::SUM_W-1];
					step_q <= rma_pkg::STEP_W'(rma_pkg::DVD_W);
					// empty ring needs no divide
					state_q <= (count_q == '0) ? ST_DONE : ST_DIVIDE;
				end
				ST_DIVIDE: begin
					if (trial_ge) begin
						rem_q <= rma_pkg::CNT_W'(trial - {1'b0, count_q});
					end else begin
						rem_q <= trial[rma_pkg::CNT_W-1:0];
					end
					quo_q  <= {quo_q[rma_pkg::DVD_W-2:0], trial_ge};
					step_q <= step_q - 1'b1;
					if (step_q == rma_pkg::STEP_W'(1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid    <= 1'b1;
						empty_res    <= (count_q == '0);
						average_q8   <= (count_q == '0) ? rma_pkg::AVG_EMPTY
							: quo_signed[rma_pkg::AVG_W-1:0];
						sample_count <= count_q;
						window_full  <= full_q;
						ready_res    <= full_q || (sum_cmp > limit_cmp);
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

	typedef struct packed {
		logic [rma_pkg::AVG_W-1:0] avg;
		logic                      empty;
		logic [rma_pkg::CNT_W-1:0] cnt;
		logic                      full;
		logic                      ready;
	} avg_result_t;

	typedef struct packed {
		logic                         act;
		logic [rma_pkg::SAMPLE_W-1:0] smp;
		logic [7:0]                   reps;
		logic                         typed;
		avg_result_t                  res;
	} dir_row_t;

	localparam int PHASES     = 8;
	localparam int PHASE_ITEMS = 216;

	logic                         clk;
	logic                         arst_n;
	logic                         cfg_wr_en;
	logic [rma_pkg::LIMIT_W-1:0]  cfg_wr_data;
	logic                         in_valid;
	logic                         in_stall;
	logic                         action;
	logic [rma_pkg::SAMPLE_W-1:0] sample;
	logic                         out_valid;
	logic                         out_stall;
	logic [rma_pkg::AVG_W-1:0]    average_q8;
	logic                         empty_res;
	logic [rma_pkg::CNT_W-1:0]    sample_count;
	logic                         window_full;
	logic                         ready_res;

	// shadow copy of the window state
	logic signed [rma_pkg::SAMPLE_W-1:0] win_ring [rma_pkg::WINDOW_LEN];
	int                                  win_ptr;
	int                                  win_count;
	logic                                win_full;
	longint                              win_sum;
	longint                              limit_q;

	avg_result_t pending_results[$];
	dir_row_t    dir_rows[$];
	int          err_count;
	bit          tx_gaps;
	bit          rx_gaps;
	int          rx_left;

	ring_moving_average_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.sample       (sample),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.average_q8   (average_q8),
		.empty_res    (empty_res),
		.sample_count (sample_count),
		.window_full  (window_full),
		.ready_res    (ready_res)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(20_000_000);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic avg_result_t predict_average(input logic act,
			input logic [rma_pkg::SAMPLE_W-1:0] smp);
		avg_result_t r;
		longint      s_new;
		longint      s_old;
		longint      q;
		if (act == rma_pkg::ACT_CLEAR) begin
			win_ptr   = 0;
			win_count = 0;
			win_full  = 1'b0;
			win_sum   = 0;
		end else begin
			s_new = longint'($signed(smp));
			s_old = longint'(win_ring[win_ptr]);
			win_ring[win_ptr] = smp;
			if (win_full)
				win_sum = win_sum + s_new - s_old;
			else
				win_sum = win_sum + s_new;
			win_ptr = (win_ptr == rma_pkg::WINDOW_LEN - 1) ? 0 : win_ptr + 1;
			if (win_count < rma_pkg::WINDOW_LEN) begin
				win_count = win_count + 1;
				if (win_count == rma_pkg::WINDOW_LEN)
					win_full = 1'b1;
			end
		end
		if (win_count == 0) begin
			r.avg   = rma_pkg::AVG_EMPTY;
			r.empty = 1'b1;
		end else begin
			q       = (win_sum * 256) / longint'(win_count);
			r.avg   = q[rma_pkg::AVG_W-1:0];
			r.empty = 1'b0;
		end
		r.cnt   = win_count[rma_pkg::CNT_W-1:0];
		r.full  = win_full;
		r.ready = win_full || (win_sum > limit_q);
		return r;
	endfunction

	function automatic logic [rma_pkg::SAMPLE_W-1:0] rand_sample();
		logic [rma_pkg::SAMPLE_W-1:0] v;
		case ($urandom_range(0, 9))
			0: v = 16'h7fff;
			1: v = 16'h8000;
			2: v = 16'($urandom_range(0, 127)) - 16'd64;
			3: v = 16'($urandom_range(20000, 32767));
			4: v = 16'h0000 - 16'($urandom_range(20000, 32768));
			default: v = 16'($urandom);
		endcase
		return v;
	endfunction

	task automatic mismatch(input string msg);
		if (err_count < 10)
			$display("mismatch at %0t: %s", $time, msg);
		err_count++;
	endtask

	task automatic dir_row(input logic act, input logic [rma_pkg::SAMPLE_W-1:0] smp,
			input int reps, input logic typed, input avg_result_t res);
		dir_row_t row;
		row.act   = act;
		row.smp   = smp;
		row.reps  = reps[7:0];
		row.typed = typed;
		row.res   = res;
		dir_rows.push_back(row);
	endtask

	task automatic send_item(input logic act, input logic [rma_pkg::SAMPLE_W-1:0] smp,
			input logic typed, input avg_result_t typed_res);
		avg_result_t r;
		r = predict_average(act, smp);
		pending_results.push_back(typed ? typed_res : r);
		in_valid <= 1'b1;
		action   <= act;
		sample   <= smp;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic maybe_pause();
		if (tx_gaps && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
	endtask

	// only while idle: waits until every result is taken, then leaves a margin
	task automatic write_limit(input logic [rma_pkg::LIMIT_W-1:0] v);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		limit_q = longint'($signed(v));
	endtask

	// result side, sampled at the edge
	always @(posedge clk) begin
		avg_result_t got;
		avg_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{average_q8, empty_res, sample_count, window_full, ready_res};
			if (pending_results.size() == 0) begin
				mismatch($sformatf("result with nothing pending: avg=%h cnt=%0d",
					got.avg, got.cnt));
			end else begin
				want = pending_results.pop_front();
				if (got !== want)
					mismatch($sformatf({"exp avg=%h empty=%b cnt=%0d full=%b ready=%b, ",
						"got avg=%h empty=%b cnt=%0d full=%b ready=%b"},
						want.avg, want.empty, want.cnt, want.full, want.ready,
						got.avg, got.empty, got.cnt, got.full, got.ready));
			end
		end
	end

	// receiver stall bursts
	always @(posedge clk) begin
		int n;
		n = rx_left;
		if (n > 0)
			n = n - 1;
		else if (rx_gaps && $urandom_range(0, 7) == 0)
			n = $urandom_range(1, 15);
		rx_left = n;
		out_stall <= (n > 0);
	end

	initial begin
		avg_result_t                 none;
		avg_result_t                 empty_r;
		dir_row_t                    row;
		logic [rma_pkg::LIMIT_W-1:0] lim;
		logic                        act;
		int                          k;

		arst_n      = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = '0;
		in_valid    = 1'b0;
		action      = rma_pkg::ACT_ADD;
		sample      = '0;
		out_stall   = 1'b0;
		rx_left     = 0;
		err_count   = 0;
		tx_gaps     = 1'b1;
		rx_gaps     = 1'b1;
		for (int i = 0; i < rma_pkg::WINDOW_LEN; i++)
			win_ring[i] = '0;
		win_ptr   = 0;
		win_count = 0;
		win_full  = 1'b0;
		win_sum   = 0;
		limit_q   = 0;

		none    = '0;
		empty_r = '{rma_pkg::AVG_EMPTY, 1'b1, 5'd0, 1'b0, 1'b0};

		// limit is still at its reset value of zero here
		dir_row(rma_pkg::ACT_CLEAR, 16'h5a5a, 1, 1'b1, empty_r);
		dir_row(rma_pkg::ACT_ADD, 16'h7fff, 1, 1'b1,
			'{24'h7fff00, 1'b0, 5'd1, 1'b0, 1'b1});
		dir_row(rma_pkg::ACT_CLEAR, 16'hffff, 1, 1'b1, empty_r);
		dir_row(rma_pkg::ACT_ADD, 16'h8000, 1, 1'b1,
			'{24'h800000, 1'b0, 5'd1, 1'b0, 1'b0});
		// fill the window with the most negative value
		dir_row(rma_pkg::ACT_ADD, 16'h8000, 15, 1'b0, none);
		// overwrite the oldest entries once full
		dir_row(rma_pkg::ACT_ADD, 16'h7fff, 3, 1'b0, none);
		dir_row(rma_pkg::ACT_CLEAR, 16'ha5a5, 1, 1'b1, empty_r);
		// clear of an already empty window
		dir_row(rma_pkg::ACT_CLEAR, 16'h0000, 1, 1'b1, empty_r);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		while (dir_rows.size() != 0) begin
			row = dir_rows.pop_front();
			for (int r = 0; r < row.reps; r++) begin
				send_item(row.act, row.smp, row.typed, row.res);
				maybe_pause();
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: lim = 20'h80000;
				1: lim = 20'h7ffff;
				2: lim = 20'h00000;
				3: lim = 20'($urandom);
				4: lim = 20'($urandom_range(0, 140000)) - 20'd70000;
				5: lim = 20'hfffff;
				6: lim = 20'($urandom_range(0, 40000));
				default: lim = 20'($urandom);
			endcase
			write_limit(lim);
			for (k = 0; k < PHASE_ITEMS; k++) begin
				if (p == PHASES - 1) begin
					tx_gaps = 1'b0;
					rx_gaps = 1'b0;
				end else begin
					tx_gaps = ((k / 60) % 3) != 2;
					rx_gaps = ((k / 60) % 3) != 1;
				end
				act = ($urandom_range(0, 29) == 0) ? rma_pkg::ACT_CLEAR : rma_pkg::ACT_ADD;
				send_item(act, rand_sample(), 1'b0, none);
				maybe_pause();
			end
		end

		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (48) @(posedge clk);
		if (err_count == 0 && pending_results.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
